FILE: src/subsampled_ycbcr_to_rgb_assert.svh
// Assertion macros for the subsampled YCbCr to RGB converter.
// Each macro expects signals clk and rst_n in the including module.
`ifndef SUBSAMPLED_YCBCR_TO_RGB_ASSERT_SVH
`define SUBSAMPLED_YCBCR_TO_RGB_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SYC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("subsampled_ycbcr_to_rgb: check failed");

// Next-cycle implication, checked out of reset.
`define SYC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("subsampled_ycbcr_to_rgb: check failed");

`endif

FILE: src/syc2rgb_pkg.sv
// Shared types, constants and arithmetic helpers for the YCbCr to RGB converter.
// No dependencies.
package syc2rgb_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;
    localparam int DEFAULT_MAX_BITS   = 16;

    localparam int SAMPLE_W   = 16;
    localparam int BITS_CFG_W = 5;
    localparam int MODE_CFG_W = 2;
    localparam int DIM_CFG_W  = 13;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 36;
    localparam int QUOT_W     = 20;
    localparam int SUM_W      = 21;

    localparam logic [BITS_CFG_W-1:0] RST_SAMPLE_BITS  = 5'd8;
    localparam logic [DIM_CFG_W-1:0]  RST_LINE_WIDTH   = 13'd1920;
    localparam logic [DIM_CFG_W-1:0]  RST_FRAME_HEIGHT = 13'd1080;

    // Q16 matrix coefficients, rounded to nearest
    localparam logic signed [17:0] K_CR_R = 18'sd91881;
    localparam logic signed [17:0] K_CB_G = 18'sd22544;
    localparam logic signed [17:0] K_CR_G = 18'sd46793;
    localparam logic signed [17:0] K_CB_B = 18'sd116130;
    localparam logic signed [PROD_W-1:0] Q16_BIAS = 36'sd65535;

    typedef enum logic [1:0] {
        REG_SAMPLE_BITS  = 2'd0,
        REG_CHROMA_MODE  = 2'd1,
        REG_LINE_WIDTH   = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_444 = 2'd0,
        MODE_422 = 2'd1,
        MODE_420 = 2'd2
    } chroma_mode_t;

    // Divide by 65536, rounding toward zero.
    function automatic logic signed [QUOT_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] biased;
        biased = p + (p[PROD_W-1] ? Q16_BIAS : '0);
        return QUOT_W'(biased >>> 16);
    endfunction

    // Clamp a signed sum to 0..upb.
    function automatic logic [SAMPLE_W-1:0] clamp_out(input logic signed [SUM_W-1:0] v,
                                                      input logic [SAMPLE_W-1:0] upb);
        logic signed [SUM_W-1:0] lim;
        lim = $signed({5'b0, upb});
        if (v < 0)
        begin
            return '0;
        end
        else if (v > lim)
        begin
            return upb;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: src/subsampled_ycbcr_to_rgb.sv
// Subsampled YCbCr to RGB converter: chroma upsampling with a line buffer and
// a pipelined Q16 matrix. Depends on syc2rgb_pkg and subsampled_ycbcr_to_rgb_assert.svh.
//
//  channel   signals                               direction
//  pixel     pix_valid/pix_stall, luma, chroma_*   in
//  rgb       rgb_valid/rgb_stall, red/green/blue,  out
//            frame_end
//  config    psel/penable/pwrite/paddr/pwdata      in, prdata/pready out
//
// One pixel per clock sustained while rgb_stall is low; each taken beat passes the input
// register plus line read, then the multiply, Q16 truncate and add-and-clamp registers.
// The line buffer takes at most one write or one read per cycle, never both at once.
// rst_n clears counters, held chroma and pipeline valids; the line buffer is
// not cleared. A stall on rgb backs up the pipeline and raises pix_stall only
// when every stage is full.
module subsampled_ycbcr_to_rgb #(
    parameter int MAX_WIDTH  = syc2rgb_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = syc2rgb_pkg::DEFAULT_MAX_HEIGHT,
    parameter int MAX_BITS   = syc2rgb_pkg::DEFAULT_MAX_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [syc2rgb_pkg::ADDR_W-1:0]      paddr,
    input  logic [syc2rgb_pkg::DATA_W-1:0]      pwdata,
    output logic [syc2rgb_pkg::DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  logic [syc2rgb_pkg::SAMPLE_W-1:0]    luma,
    input  logic [syc2rgb_pkg::SAMPLE_W-1:0]    chroma_blue,
    input  logic [syc2rgb_pkg::SAMPLE_W-1:0]    chroma_red,
    output logic                                rgb_valid,
    input  logic                                rgb_stall,
    output logic [syc2rgb_pkg::SAMPLE_W-1:0]    red,
    output logic [syc2rgb_pkg::SAMPLE_W-1:0]    green,
    output logic [syc2rgb_pkg::SAMPLE_W-1:0]    blue,
    output logic                                frame_end
);

    localparam int SW         = syc2rgb_pkg::SAMPLE_W;
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW         = (CW + 1 > syc2rgb_pkg::DIM_CFG_W) ? CW + 1
                                                                  : syc2rgb_pkg::DIM_CFG_W;
    localparam int HW         = (RW + 1 > syc2rgb_pkg::DIM_CFG_W) ? RW + 1
                                                                  : syc2rgb_pkg::DIM_CFG_W;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int BW         = syc2rgb_pkg::BITS_CFG_W;
    localparam int PW         = syc2rgb_pkg::PROD_W;
    localparam int QW         = syc2rgb_pkg::QUOT_W;
    localparam int XW         = syc2rgb_pkg::SUM_W;

    // configuration registers
    logic [BW-1:0]                           bits_reg;
    logic [syc2rgb_pkg::MODE_CFG_W-1:0]      mode_reg;
    logic [syc2rgb_pkg::DIM_CFG_W-1:0]       lwidth_reg;
    logic [syc2rgb_pkg::DIM_CFG_W-1:0]       fheight_reg;
    logic                                    cfg_wr;
    syc2rgb_pkg::cfg_reg_t                   cfg_sel;

    // position and held chroma
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [2*SW-1:0]   held_reg, held_next;

    // effective settings
    logic [BW-1:0]     bits_eff;
    logic [WW-1:0]     width_eff;
    logic [HW-1:0]     height_eff;
    logic [SW:0]       offset;
    logic [SW-1:0]     upb;

    // front-end decode
    logic              last_col, last_row, even_col, even_row;
    logic [CW-1:0]     idx;
    logic              idx_ok;
    logic [2*SW-1:0]   fresh, chroma_pick;
    logic              use_line, mem_we, mem_re;

    // pipeline control
    logic              en1, en2, en3, en_out, pix_acc;
    logic              v1_reg, v2_reg, v3_reg, vout_reg;

    // line buffer
    logic [2*SW-1:0]   line_mem [LINE_DEPTH];
    logic [2*SW-1:0]   line_q_reg;

    // stage 1
    logic [SW-1:0]     s1_luma_reg;
    logic [2*SW-1:0]   s1_chroma_reg;
    logic              s1_use_line_reg, s1_zero_reg, s1_end_reg;
    logic [2*SW-1:0]   s1_chroma;
    logic signed [SW:0] cb_s, cr_s;
    logic signed [PW-1:0] pr, pgb, pgr, pb;

    // stage 2
    logic signed [PW-1:0] s2_pr_reg, s2_pgb_reg, s2_pgr_reg, s2_pb_reg;
    logic [SW-1:0]     s2_luma_reg;
    logic              s2_end_reg;

    // stage 3
    logic signed [QW-1:0] s3_qr_reg, s3_qg_reg, s3_qb_reg;
    logic [SW-1:0]     s3_luma_reg;
    logic              s3_end_reg;
    logic signed [XW-1:0] sum_r, sum_g, sum_b;

    // output register
    logic [SW-1:0]     red_reg, green_reg, blue_reg;
    logic              end_reg;

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_sel = syc2rgb_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg    <= syc2rgb_pkg::RST_SAMPLE_BITS;
            mode_reg    <= syc2rgb_pkg::MODE_444;
            lwidth_reg  <= syc2rgb_pkg::RST_LINE_WIDTH;
            fheight_reg <= syc2rgb_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                syc2rgb_pkg::REG_SAMPLE_BITS:  bits_reg    <= pwdata[BW-1:0];
                syc2rgb_pkg::REG_CHROMA_MODE:  mode_reg    <= pwdata[syc2rgb_pkg::MODE_CFG_W-1:0];
                syc2rgb_pkg::REG_LINE_WIDTH:   lwidth_reg  <= pwdata[syc2rgb_pkg::DIM_CFG_W-1:0];
                syc2rgb_pkg::REG_FRAME_HEIGHT: fheight_reg <= pwdata[syc2rgb_pkg::DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            syc2rgb_pkg::REG_SAMPLE_BITS:  prdata = 32'(bits_reg);
            syc2rgb_pkg::REG_CHROMA_MODE:  prdata = 32'(mode_reg);
            syc2rgb_pkg::REG_LINE_WIDTH:   prdata = 32'(lwidth_reg);
            syc2rgb_pkg::REG_FRAME_HEIGHT: prdata = 32'(fheight_reg);
            default:                       prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Effective settings
    //------------------------------------------------------------------
    always_comb
    begin
        if (bits_reg == '0)
            bits_eff = BW'(1);
        else if (bits_reg > BW'(MAX_BITS))
            bits_eff = BW'(MAX_BITS);
        else
            bits_eff = bits_reg;

        if (lwidth_reg == '0)
            width_eff = WW'(1);
        else if (WW'(lwidth_reg) > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(lwidth_reg);

        if (fheight_reg == '0)
            height_eff = HW'(1);
        else if (HW'(fheight_reg) > HW'(MAX_HEIGHT))
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = HW'(fheight_reg);
    end

    assign offset = (SW + 1)'(1) << (bits_eff - BW'(1));
    assign upb    = SW'(((SW + 1)'(1) << bits_eff) - (SW + 1)'(1));

    //------------------------------------------------------------------
    // Pipeline control: each stage advances when the next one frees up
    //------------------------------------------------------------------
    assign en_out    = !vout_reg || !rgb_stall;
    assign en3       = !v3_reg || en_out;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign pix_stall = !en1;
    assign pix_acc   = pix_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= pix_acc;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en_out)
                vout_reg <= v3_reg;
        end
    end

    //------------------------------------------------------------------
    // Position and chroma selection
    //------------------------------------------------------------------
    assign last_col = (WW'(col_reg) + WW'(1)) >= width_eff;
    assign last_row = (HW'(row_reg) + HW'(1)) >= height_eff;
    assign even_col = !col_reg[0];
    assign even_row = !row_reg[0];
    assign idx      = col_reg >> 1;
    assign idx_ok   = 32'(idx) < LINE_DEPTH;
    assign fresh    = {chroma_red, chroma_blue};

    always_comb
    begin
        held_next   = held_reg;
        chroma_pick = fresh;
        use_line    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (syc2rgb_pkg::chroma_mode_t'(mode_reg))
            syc2rgb_pkg::MODE_422:
            begin
                if (even_col)
                    held_next = fresh;
                chroma_pick = held_next;
            end
            syc2rgb_pkg::MODE_420:
            begin
                if (even_row)
                begin
                    if (even_col)
                    begin
                        held_next = fresh;
                        mem_we    = pix_acc && idx_ok;
                    end
                    chroma_pick = held_next;
                end
                else
                begin
                    use_line = 1'b1;
                    mem_re   = pix_acc && idx_ok;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

    //------------------------------------------------------------------
    // Line buffer (4:2:0 only): even rows write, odd rows read a full row later
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[idx[AW-1:0]] <= fresh;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            line_q_reg <= line_mem[idx[AW-1:0]];
    end

    //------------------------------------------------------------------
    // Stage 1: pick chroma, center, multiply
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_luma_reg     <= luma;
            s1_chroma_reg   <= chroma_pick;
            s1_use_line_reg <= use_line;
            s1_zero_reg     <= !idx_ok;
            s1_end_reg      <= last_col && last_row;
        end
    end

    always_comb
    begin
        if (!s1_use_line_reg)
            s1_chroma = s1_chroma_reg;
        else if (s1_zero_reg)
            s1_chroma = '0;
        else
            s1_chroma = line_q_reg;
    end

    assign cb_s = $signed({1'b0, s1_chroma[SW-1:0]}) - $signed(offset);
    assign cr_s = $signed({1'b0, s1_chroma[2*SW-1:SW]}) - $signed(offset);
    assign pr   = cr_s * syc2rgb_pkg::K_CR_R;
    assign pgb  = cb_s * syc2rgb_pkg::K_CB_G;
    assign pgr  = cr_s * syc2rgb_pkg::K_CR_G;
    assign pb   = cb_s * syc2rgb_pkg::K_CB_B;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_pr_reg   <= pr;
            s2_pgb_reg  <= pgb;
            s2_pgr_reg  <= pgr;
            s2_pb_reg   <= pb;
            s2_luma_reg <= s1_luma_reg;
            s2_end_reg  <= s1_end_reg;
        end
    end

    //------------------------------------------------------------------
    // Stage 3: Q16 truncation toward zero
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_qr_reg   <= syc2rgb_pkg::trunc_q16(s2_pr_reg);
            s3_qg_reg   <= syc2rgb_pkg::trunc_q16(s2_pgb_reg + s2_pgr_reg);
            s3_qb_reg   <= syc2rgb_pkg::trunc_q16(s2_pb_reg);
            s3_luma_reg <= s2_luma_reg;
            s3_end_reg  <= s2_end_reg;
        end
    end

    //------------------------------------------------------------------
    // Output: add luma and clamp
    //------------------------------------------------------------------
    assign sum_r = $signed({5'b0, s3_luma_reg}) + XW'(s3_qr_reg);
    assign sum_g = $signed({5'b0, s3_luma_reg}) - XW'(s3_qg_reg);
    assign sum_b = $signed({5'b0, s3_luma_reg}) + XW'(s3_qb_reg);

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            red_reg   <= syc2rgb_pkg::clamp_out(sum_r, upb);
            green_reg <= syc2rgb_pkg::clamp_out(sum_g, upb);
            blue_reg  <= syc2rgb_pkg::clamp_out(sum_b, upb);
            end_reg   <= s3_end_reg;
        end
    end

    assign rgb_valid = vout_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign frame_end = end_reg;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
`include "subsampled_ycbcr_to_rgb_assert.svh"

    `SYC_ASSERT_SAME(a_stall_only_when_full, pix_stall, v1_reg && v2_reg && v3_reg && vout_reg && rgb_stall)
    `SYC_ASSERT_SAME(a_line_rw_exclusive, mem_we || mem_re, !(mem_we && mem_re))
    `SYC_ASSERT_NEXT(a_col_wraps, pix_acc && last_col, col_reg == '0)
    `SYC_ASSERT_SAME(a_red_clamped, rgb_valid, red <= upb && green <= upb && blue <= upb)

endmodule

FILE: test/tb_subsampled_ycbcr_to_rgb.sv
// Self-checking testbench for subsampled_ycbcr_to_rgb: pixel stream in, RGB beats out,
// registers written over the APB-style port between phases.
// Depends on syc2rgb_pkg and the RTL of subsampled_ycbcr_to_rgb.
module tb_subsampled_ycbcr_to_rgb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SW            = syc2rgb_pkg::SAMPLE_W;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned RANDOM_PIXELS = 450;
    localparam int unsigned CALM_TAIL     = 60;
    localparam int unsigned HOLD_CYCLES   = 100;
    localparam int unsigned BITS_CAP      = syc2rgb_pkg::DEFAULT_MAX_BITS;
    localparam int unsigned WIDTH_CAP     = syc2rgb_pkg::DEFAULT_MAX_WIDTH;
    localparam int unsigned HEIGHT_CAP    = syc2rgb_pkg::DEFAULT_MAX_HEIGHT;
    localparam int unsigned LINE_ENTRIES  = syc2rgb_pkg::DEFAULT_MAX_WIDTH / 2;

    localparam longint CR_TO_R = 91881;
    localparam longint CB_TO_G = 22544;
    localparam longint CR_TO_G = 46793;
    localparam longint CB_TO_B = 116130;
    localparam longint Q16_ONE = 65536;

    // mode code with no meaning of its own; converts as 4:4:4
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [SW-1:0] red;
        logic [SW-1:0] green;
        logic [SW-1:0] blue;
        logic          frame_end;
    } rgb_beat_t;

    // Tracks the converter's registers, raster position and chroma stores, and
    // holds the RGB beats still owed by the block.
    class rgb_tracker;
        logic [4:0]          sample_bits;
        logic [1:0]          chroma_mode;
        logic [12:0]         line_width;
        logic [12:0]         frame_height;
        int unsigned         col;
        int unsigned         row;
        logic [31:0]         held;
        logic [31:0]         line_mem [LINE_ENTRIES];
        rgb_beat_t           rgb_due [$];
        int unsigned         errors;
        int unsigned         pixels;
        int unsigned         frames;

        function new();
            sample_bits  = syc2rgb_pkg::RST_SAMPLE_BITS;
            chroma_mode  = syc2rgb_pkg::MODE_444;
            line_width   = syc2rgb_pkg::RST_LINE_WIDTH;
            frame_height = syc2rgb_pkg::RST_FRAME_HEIGHT;
            col = 0;
            row = 0;
            held = '0;
            errors = 0;
            pixels = 0;
            frames = 0;
        endfunction

        function void set_reg(syc2rgb_pkg::cfg_reg_t idx, logic [31:0] value);
            case (idx)
                syc2rgb_pkg::REG_SAMPLE_BITS:  sample_bits  = value[4:0];
                syc2rgb_pkg::REG_CHROMA_MODE:  chroma_mode  = value[1:0];
                syc2rgb_pkg::REG_LINE_WIDTH:   line_width   = value[12:0];
                syc2rgb_pkg::REG_FRAME_HEIGHT: frame_height = value[12:0];
                default: ;
            endcase
        endfunction

        function bit at_origin();
            return col == 0 && row == 0;
        endfunction

        function int unsigned pending();
            return rgb_due.size();
        endfunction

        function longint clip(longint v, longint hi);
            if (v < 0)
                return 0;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void note_pixel(logic [15:0] y, logic [15:0] cb, logic [15:0] cr);
            int unsigned bits;
            int unsigned width;
            int unsigned height;
            int unsigned idx;
            logic [31:0] fresh;
            logic [31:0] chroma;
            bit          last_col;
            bit          last_row;
            longint      offset;
            longint      upb;
            longint      cb_c;
            longint      cr_c;
            longint      r;
            longint      g;
            longint      b;
            rgb_beat_t   beat;

            bits   = (sample_bits == 0) ? 1 : ((sample_bits > BITS_CAP) ? BITS_CAP : sample_bits);
            width  = (line_width == 0) ? 1 : ((line_width > WIDTH_CAP) ? WIDTH_CAP : line_width);
            height = (frame_height == 0) ? 1
                   : ((frame_height > HEIGHT_CAP) ? HEIGHT_CAP : frame_height);
            offset = longint'(1) << (bits - 1);
            upb    = (longint'(1) << bits) - 1;
            fresh  = {cr, cb};
            idx    = col >> 1;
            last_col = (col + 1 >= width);
            last_row = (row + 1 >= height);

            if (chroma_mode == syc2rgb_pkg::MODE_422)
            begin
                if (col[0] == 1'b0)
                    held = fresh;
                chroma = held;
            end
            else if (chroma_mode == syc2rgb_pkg::MODE_420)
            begin
                if (row[0] == 1'b0)
                begin
                    // even row: sample and park it for the odd row below
                    if (col[0] == 1'b0)
                    begin
                        held = fresh;
                        line_mem[idx] = fresh;
                    end
                    chroma = held;
                end
                else
                begin
                    chroma = line_mem[idx];
                end
            end
            else
            begin
                chroma = fresh;
            end

            cb_c = longint'(chroma[15:0]) - offset;
            cr_c = longint'(chroma[31:16]) - offset;
            // longint division truncates toward zero, as the block does
            r = longint'(y) + (CR_TO_R * cr_c) / Q16_ONE;
            g = longint'(y) - (CB_TO_G * cb_c + CR_TO_G * cr_c) / Q16_ONE;
            b = longint'(y) + (CB_TO_B * cb_c) / Q16_ONE;

            beat.red       = SW'(clip(r, upb));
            beat.green     = SW'(clip(g, upb));
            beat.blue      = SW'(clip(b, upb));
            beat.frame_end = last_col && last_row;
            rgb_due.push_back(beat);
            pixels++;

            if (last_col)
            begin
                col = 0;
                row = last_row ? 0 : row + 1;
            end
            else
            begin
                col = col + 1;
            end
        endfunction

        function void check_rgb(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic fe);
            rgb_beat_t want;

            if (rgb_due.size() == 0)
            begin
                $error("rgb beat with nothing owed: red %0h green %0h blue %0h frame_end %0b",
                       r, g, b, fe);
                errors++;
                return;
            end
            want = rgb_due.pop_front();
            if (fe === 1'b1)
                frames++;
            if (r !== want.red)
            begin
                $error("red: expected %0h, got %0h", want.red, r);
                errors++;
            end
            if (g !== want.green)
            begin
                $error("green: expected %0h, got %0h", want.green, g);
                errors++;
            end
            if (b !== want.blue)
            begin
                $error("blue: expected %0h, got %0h", want.blue, b);
                errors++;
            end
            if (fe !== want.frame_end)
            begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [syc2rgb_pkg::ADDR_W-1:0]     paddr = '0;
    logic [syc2rgb_pkg::DATA_W-1:0]     pwdata = '0;
    logic [syc2rgb_pkg::DATA_W-1:0]     prdata;
    logic                               pready;
    logic                               pix_valid = 1'b0;
    logic                               pix_stall;
    logic [SW-1:0]                      luma = '0;
    logic [SW-1:0]                      chroma_blue = '0;
    logic [SW-1:0]                      chroma_red = '0;
    logic                               rgb_valid;
    logic                               rgb_stall = 1'b0;
    logic [SW-1:0]                      red;
    logic [SW-1:0]                      green;
    logic [SW-1:0]                      blue;
    logic                               frame_end;

    rgb_tracker  sb;
    bit          sender_idle = 1'b1;
    bit          stalls_on = 1'b1;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 0;
    int unsigned settings = 0;

    subsampled_ycbcr_to_rgb dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_end   (frame_end)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
            sb.note_pixel(luma, chroma_blue, chroma_red);
        if (rst_n && rgb_valid && !rgb_stall)
            sb.check_rgb(red, green, blue, frame_end);
    end

    // Receiver: one long hold when asked, otherwise short random stall bursts.
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rgb_stall <= 1'b1;
        end
        else if (burst_left != 0)
        begin
            burst_left--;
            rgb_stall <= 1'b1;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            burst_left = $urandom_range(1, 4) - 1;
            rgb_stall <= 1'b1;
        end
        else
        begin
            rgb_stall <= 1'b0;
        end
    end

    initial
    begin
        int unsigned quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pix_valid && !pix_stall) || (rgb_valid && !rgb_stall) || psel || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_subsampled_ycbcr_to_rgb: done, errors");
        $finish;
    end

    task automatic cfg_write(syc2rgb_pkg::cfg_reg_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic setup(logic [31:0] bits, logic [31:0] mode, logic [31:0] width,
                         logic [31:0] height);
        cfg_write(syc2rgb_pkg::REG_SAMPLE_BITS, bits);
        cfg_write(syc2rgb_pkg::REG_CHROMA_MODE, mode);
        cfg_write(syc2rgb_pkg::REG_LINE_WIDTH, width);
        cfg_write(syc2rgb_pkg::REG_FRAME_HEIGHT, height);
        settings++;
    endtask

    // Offer one beat and hold it until the block takes it.
    task automatic push_pixel(logic [15:0] y, logic [15:0] cb, logic [15:0] cr);
        if (sender_idle && $urandom_range(0, 4) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix_valid   <= 1'b1;
        luma        <= y;
        chroma_blue <= cb;
        chroma_red  <= cr;
        do
            @(posedge clk);
        while (pix_stall);
    endtask

    // Drop valid and wait until every owed beat is back.
    task automatic end_burst();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample(int unsigned bits);
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'((32'd1 << bits) - 1);
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, (32'd1 << bits) - 1));
        endcase
    endfunction

    task automatic send_random(int unsigned n, int unsigned bits);
        repeat (n)
            push_pixel(rand_sample(bits), rand_sample(bits), rand_sample(bits));
        end_burst();
    endtask

    // Return the raster position to the frame origin with one 1x1 frame in 4:4:4,
    // so that a following 4:2:0 phase reads only line entries it wrote itself.
    task automatic realign();
        cfg_write(syc2rgb_pkg::REG_CHROMA_MODE, syc2rgb_pkg::MODE_444);
        cfg_write(syc2rgb_pkg::REG_LINE_WIDTH, 32'd1);
        cfg_write(syc2rgb_pkg::REG_FRAME_HEIGHT, 32'd1);
        push_pixel(16'($urandom), 16'($urandom), 16'($urandom));
        end_burst();
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned n;
        int unsigned eff_bits;
        logic [31:0] bits_v;
        logic [31:0] mode_v;
        logic [31:0] width_v;
        logic [31:0] height_v;
        bit          wide;

        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 8 bits, 4:4:4, mid-scale gray
        push_pixel(16'h0080, 16'h0080, 16'h0080);
        end_burst();

        // full precision, extremes of every field
        setup(32'd16, syc2rgb_pkg::MODE_444, 32'd4, 32'd2);
        push_pixel(16'h0000, 16'h0000, 16'h0000);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pixel(16'h0000, 16'hFFFF, 16'h0000);
        push_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        push_pixel(16'h8000, 16'h8000, 16'h8000);
        push_pixel(16'h0000, 16'h0000, 16'hFFFF);
        push_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        end_burst();

        // zero precision and zero sizes, spare mode code, inputs wider than the precision
        setup(32'd0, MODE_SPARE, 32'd0, 32'd0);
        push_pixel(16'h0001, 16'h0000, 16'h0001);
        push_pixel(16'h0000, 16'h0001, 16'h0000);
        push_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        end_burst();

        // oversized precision and sizes saturate
        setup(32'd31, syc2rgb_pkg::MODE_422, 32'd8191, 32'd8191);
        push_pixel(16'h1234, 16'hFFFF, 16'h0000);
        push_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        push_pixel(16'h0000, 16'h8000, 16'h7FFF);
        end_burst();

        // shrink mid-frame: column already past the new width
        setup(32'd8, syc2rgb_pkg::MODE_422, 32'd2, 32'd2);
        push_pixel(16'h00FF, 16'h0000, 16'h00FF);
        push_pixel(16'h0010, 16'h00FF, 16'h0000);
        push_pixel(16'h0020, 16'h0001, 16'h00FE);
        end_burst();

        // 4:2:0 with an odd width and an odd height
        if (!sb.at_origin())
            realign();
        setup(32'd10, syc2rgb_pkg::MODE_420, 32'd3, 32'd3);
        send_random(9, 10);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_PIXELS)
        begin
            phase++;
            sender_idle = (random_items + CALM_TAIL < RANDOM_PIXELS) && (phase % 5 != 2);
            stalls_on   = (random_items + CALM_TAIL < RANDOM_PIXELS) && (phase % 5 != 4);

            case ($urandom_range(0, 9))
                0: bits_v = 32'd0;
                1: bits_v = $urandom_range(17, 31);
                2: bits_v = 32'd16;
                3: bits_v = 32'd1;
                default: bits_v = $urandom_range(2, 15);
            endcase
            mode_v = $urandom_range(0, 3);
            wide = 1'b0;
            case ($urandom_range(0, 11))
                0: width_v = 32'd0;
                1:
                begin
                    width_v = 32'd8191;
                    wide = 1'b1;
                end
                2:
                begin
                    width_v = 32'd4096;
                    wide = 1'b1;
                end
                default: width_v = $urandom_range(1, 10);
            endcase
            case ($urandom_range(0, 9))
                0: height_v = 32'd0;
                1: height_v = 32'd8191;
                default: height_v = $urandom_range(1, 5);
            endcase
            n = wide ? $urandom_range(2, 6) : $urandom_range(8, 40);

            if (mode_v[1:0] == syc2rgb_pkg::MODE_420 && !sb.at_origin())
                realign();
            setup(bits_v, mode_v, width_v, height_v);

            eff_bits = (bits_v == 0) ? 1 : ((bits_v > BITS_CAP) ? BITS_CAP : bits_v);
            if (phase == 3)
            begin
                // long receiver hold while the sender keeps offering: fill the pipe
                sender_idle = 1'b0;
                hold_req = HOLD_CYCLES;
                n = 40;
            end
            send_random(n, eff_bits);
            random_items += n;
        end

        sender_idle = 1'b0;
        stalls_on = 1'b0;
        end_burst();
        repeat (20) @(posedge clk);

        $display("converted %0d pixels, %0d frames closed, over %0d register settings",
                 sb.pixels, sb.frames, settings);
        $display("modes 4:4:4, 4:2:2, 4:2:0 and the spare code; precisions 0..31; sizes 0..8191");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_subsampled_ycbcr_to_rgb: done, clean");
        else
            $display("tb_subsampled_ycbcr_to_rgb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/syc2rgb_pkg.sv
src/subsampled_ycbcr_to_rgb.sv
test/tb_subsampled_ycbcr_to_rgb.sv
